// File: rtl/ste_pkg.sv
`default_nettype none
package ste_pkg;

    localparam int COLS = 64;
    localparam int MAX_QUBITS_DEF = 64;

    localparam logic [3:0] CMD_H      = 4'd0;
    localparam logic [3:0] CMD_X      = 4'd1;
    localparam logic [3:0] CMD_Y      = 4'd2;
    localparam logic [3:0] CMD_Z      = 4'd3;
    localparam logic [3:0] CMD_CX     = 4'd4;
    localparam logic [3:0] CMD_CZ     = 4'd5;
    localparam logic [3:0] CMD_SWAP   = 4'd6;
    localparam logic [3:0] CMD_FINISH = 4'd7;
    localparam logic [3:0] CMD_INIT   = 4'd8;

    typedef struct packed {
        logic              sign;
        logic [COLS-1:0]   z;
        logic [COLS-1:0]   x;
    } row_t;

    typedef struct packed {
        logic odd;
        row_t row;
    } prod_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GATE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_ELIM_RD,
        ST_ELIM_CHK,
        ST_BS_RD,
        ST_BS_CHK,
        ST_EMIT,
        ST_EM_RD,
        ST_EM_LOAD,
        ST_OUT
    } state_t;

    function automatic row_t gate_h(row_t r, logic [5:0] q);
        row_t o;
        logic xq;
        logic zq;
        o = r;
        xq = r.x[q];
        zq = r.z[q];
        o.sign = r.sign ^ (xq & zq);
        o.x[q] = zq;
        o.z[q] = xq;
        return o;
    endfunction

    function automatic row_t gate_cx(row_t r, logic [5:0] c, logic [5:0] t);
        row_t o;
        logic xc;
        logic xt;
        logic zc;
        logic zt;
        o = r;
        xc = r.x[c];
        xt = r.x[t];
        zc = r.z[c];
        zt = r.z[t];
        o.sign = r.sign ^ (xc & zt & ~(xt ^ zc));
        o.x[t] = xt ^ xc;
        o.z[c] = zc ^ zt;
        return o;
    endfunction

    function automatic row_t gate_row(row_t r, logic [3:0] cmd, logic [5:0] a,
                                      logic [5:0] b);
        row_t o;
        o = r;
        case (cmd)
            CMD_H: o = gate_h(r, a);
            CMD_X: o.sign = r.sign ^ r.z[a];
            CMD_Y: o.sign = r.sign ^ r.x[a] ^ r.z[a];
            CMD_Z: o.sign = r.sign ^ r.x[a];
            CMD_CX: o = gate_cx(r, a, b);
            CMD_CZ: o = gate_h(gate_cx(gate_h(r, b), a, b), b);
            CMD_SWAP: begin
                o.x[a] = r.x[b];
                o.x[b] = r.x[a];
                o.z[a] = r.z[b];
                o.z[b] = r.z[a];
            end
            default: o = r;
        endcase
        return o;
    endfunction

    // target row t times source row s, columns limited by m
    function automatic prod_t row_product(row_t t, row_t s, logic [COLS-1:0] m);
        prod_t o;
        logic [COLS-1:0] tx;
        logic [COLS-1:0] tz;
        logic [COLS-1:0] sx;
        logic [COLS-1:0] sz;
        logic [1:0] e;
        tx = t.x & m;
        tz = t.z & m;
        sx = s.x & m;
        sz = s.z & m;
        e = {t.sign, 1'b0} + {s.sign, 1'b0}
            + 2'($countones(tx & tz)) + 2'($countones(sx & sz))
            + {1'($countones(tz & sx)), 1'b0}
            - 2'($countones((tx ^ sx) & (tz ^ sz)));
        o.odd = e[0];
        o.row.sign = e[1];
        o.row.x = (t.x ^ sx) & m;
        o.row.z = (t.z ^ sz) & m;
        return o;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ste_row_ram.sv
`default_nettype none
module ste_row_ram #(
    parameter int DEPTH = ste_pkg::MAX_QUBITS_DEF,
    parameter int AW    = $clog2(ste_pkg::MAX_QUBITS_DEF)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire ste_pkg::row_t wdata,
    input  wire logic [AW-1:0] raddr,
    output ste_pkg::row_t      rdata
);

    ste_pkg::row_t mem [DEPTH];
    ste_pkg::row_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/stabilizer_tableau_engine.sv
`default_nettype none
// Stabilizer tableau engine. Rows of the tableau (X bits, Z bits, sign) sit in one
// synchronous single-write memory and are read, modified and written back one row at
// a time. After reset, and after an init command, a clearing pass rewrites every one
// of the MAX_QUBITS rows before the next word is taken. A gate word streams the n
// active rows through the memory port, one row per cycle. A finish word runs a pivot
// search and elimination, each row visited by a read state and a check state, then a
// back-substitution, followed by one result word per generator (a single word at rank
// zero), each plus the wait on m_tready. Words outside the command set, gates naming
// qubits at or beyond n and CX or CZ words naming one qubit twice are dropped.
module stabilizer_tableau_engine #(
    parameter int MAX_QUBITS = ste_pkg::MAX_QUBITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // command, first_qubit, second_qubit
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata,   // x_rank, base_outcome, generator_index, generator_bits
    output logic              m_tlast,
    output logic              m_tuser,   // status
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [6:0]   cfg_data
);

    localparam int AW = $clog2(MAX_QUBITS);
    localparam int CW = $clog2(MAX_QUBITS + 1);
    localparam int COLS = ste_pkg::COLS;

    ste_pkg::state_t state_reg, state_next;
    logic [6:0]      active_reg;
    logic [3:0]      cmd_reg, cmd_next;
    logic [5:0]      a_reg, a_next;
    logic [5:0]      b_reg, b_next;
    logic [CW-1:0]   row_reg, row_next;
    logic            pend_reg, pend_next;
    logic [CW-1:0]   paddr_reg, paddr_next;
    logic [CW-1:0]   q_reg, q_next;
    logic [CW-1:0]   pivot_reg, pivot_next;
    logic [CW-1:0]   sel_reg, sel_next;
    logic [CW-1:0]   r_reg, r_next;
    logic [CW-1:0]   rank_reg, rank_next;
    logic            zph_reg, zph_next;
    logic            err_reg, err_next;
    ste_pkg::row_t   sv_reg, sv_next;
    logic [COLS-1:0] pcol_reg, pcol_next;
    logic [COLS-1:0] base_reg, base_next;
    logic [6:0]      out_rank_reg, out_rank_next;
    logic [5:0]      out_idx_reg, out_idx_next;
    logic [COLS-1:0] out_bits_reg, out_bits_next;
    logic            out_last_reg, out_last_next;

    logic [CW-1:0]   n;
    logic [COLS-1:0] m;
    logic [5:0]      qc;
    logic            we;
    logic [AW-1:0]   waddr;
    ste_pkg::row_t   wdata;
    logic [AW-1:0]   raddr;
    ste_pkg::row_t   rdata;
    ste_pkg::prod_t  prod;
    logic            hit;
    logic [3:0]      in_cmd;
    logic [5:0]      in_a;
    logic [5:0]      in_b;
    logic            a_ok;
    logic            b_ok;

    ste_row_ram #(
        .DEPTH (MAX_QUBITS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        if (active_reg == 7'd0) begin
            n = CW'(1);
        end else if (active_reg > 7'(MAX_QUBITS)) begin
            n = CW'(MAX_QUBITS);
        end else begin
            n = CW'(active_reg);
        end
    end

    assign m      = ~({COLS{1'b1}} << n);
    assign qc     = 6'(q_reg);
    assign prod   = ste_pkg::row_product(rdata, sv_reg, m);
    assign hit    = zph_reg ? rdata.z[qc] : rdata.x[qc];
    assign in_cmd = s_tdata[3:0];
    assign in_a   = s_tdata[9:4];
    assign in_b   = s_tdata[15:10];
    assign a_ok   = 7'(in_a) < 7'(n);
    assign b_ok   = 7'(in_b) < 7'(n);

    assign s_tready  = (state_reg == ste_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ste_pkg::ST_OUT);
    assign m_tdata   = {3'b000, out_bits_reg, out_idx_reg, base_reg, out_rank_reg};
    assign m_tlast   = out_last_reg;
    assign m_tuser   = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ste_pkg::ST_CLEAR;
            active_reg <= 7'd64;
            row_reg    <= '0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            if (cfg_valid && cfg_ready) begin
                active_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        paddr_reg    <= paddr_next;
        q_reg        <= q_next;
        pivot_reg    <= pivot_next;
        sel_reg      <= sel_next;
        r_reg        <= r_next;
        rank_reg     <= rank_next;
        zph_reg      <= zph_next;
        err_reg      <= err_next;
        sv_reg       <= sv_next;
        pcol_reg     <= pcol_next;
        base_reg     <= base_next;
        out_rank_reg <= out_rank_next;
        out_idx_reg  <= out_idx_next;
        out_bits_reg <= out_bits_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        row_next      = row_reg;
        pend_next     = pend_reg;
        paddr_next    = paddr_reg;
        q_next        = q_reg;
        pivot_next    = pivot_reg;
        sel_next      = sel_reg;
        r_next        = r_reg;
        rank_next     = rank_reg;
        zph_next      = zph_reg;
        err_next      = err_reg;
        sv_next       = sv_reg;
        pcol_next     = pcol_reg;
        base_next     = base_reg;
        out_rank_next = out_rank_reg;
        out_idx_next  = out_idx_reg;
        out_bits_next = out_bits_reg;
        out_last_next = out_last_reg;
        we            = 1'b0;
        waddr         = AW'(row_reg);
        wdata         = rdata;
        raddr         = AW'(row_reg);

        unique case (state_reg)
            ste_pkg::ST_CLEAR: begin
                we          = 1'b1;
                waddr       = AW'(row_reg);
                wdata.sign  = 1'b0;
                wdata.x     = '0;
                wdata.z     = COLS'(1) << row_reg;
                row_next    = row_reg + CW'(1);
                if (row_reg == CW'(MAX_QUBITS - 1)) begin
                    state_next = ste_pkg::ST_IDLE;
                end
            end

            ste_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = in_cmd;
                    a_next   = in_a;
                    b_next   = in_b;
                    row_next = '0;
                    unique case (in_cmd) inside
                        ste_pkg::CMD_INIT: state_next = ste_pkg::ST_CLEAR;
                        ste_pkg::CMD_H, ste_pkg::CMD_X, ste_pkg::CMD_Y, ste_pkg::CMD_Z: begin
                            if (a_ok) begin
                                pend_next  = 1'b0;
                                state_next = ste_pkg::ST_GATE;
                            end
                        end
                        ste_pkg::CMD_CX, ste_pkg::CMD_CZ: begin
                            if (a_ok && b_ok && (in_a != in_b)) begin
                                pend_next  = 1'b0;
                                state_next = ste_pkg::ST_GATE;
                            end
                        end
                        ste_pkg::CMD_SWAP: begin
                            if (a_ok && b_ok) begin
                                pend_next  = 1'b0;
                                state_next = ste_pkg::ST_GATE;
                            end
                        end
                        ste_pkg::CMD_FINISH: begin
                            q_next     = '0;
                            pivot_next = '0;
                            sel_next   = '0;
                            zph_next   = 1'b0;
                            err_next   = 1'b0;
                            pcol_next  = '0;
                            base_next  = '0;
                            state_next = ste_pkg::ST_SCAN_RD;
                        end
                        default: state_next = ste_pkg::ST_IDLE;
                    endcase
                end
            end

            ste_pkg::ST_GATE: begin
                raddr = AW'(row_reg);
                if (row_reg < n) begin
                    row_next   = row_reg + CW'(1);
                    pend_next  = 1'b1;
                    paddr_next = row_reg;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    we    = 1'b1;
                    waddr = AW'(paddr_reg);
                    wdata = ste_pkg::gate_row(rdata, cmd_reg, a_reg, b_reg);
                end
                if (row_reg >= n && !pend_reg) begin
                    state_next = ste_pkg::ST_IDLE;
                end
            end

            ste_pkg::ST_SCAN_RD: begin
                raddr = AW'(sel_reg);
                if (q_reg >= n || pivot_reg >= n) begin
                    if (!zph_reg) begin
                        rank_next = pivot_reg;
                        zph_next  = 1'b1;
                        q_next    = '0;
                        sel_next  = pivot_reg;
                    end else begin
                        if (pivot_reg != n) begin
                            err_next = 1'b1;
                        end
                        q_next     = n - CW'(1);
                        row_next   = pivot_reg - CW'(1);
                        state_next = ste_pkg::ST_BS_RD;
                    end
                end else if (sel_reg >= n) begin
                    q_next   = q_reg + CW'(1);
                    sel_next = pivot_reg;
                end else begin
                    state_next = ste_pkg::ST_SCAN_CHK;
                end
            end

            ste_pkg::ST_SCAN_CHK: begin
                raddr = AW'(pivot_reg);
                if (hit) begin
                    sv_next    = rdata;
                    state_next = ste_pkg::ST_SWAP_A;
                end else begin
                    sel_next   = sel_reg + CW'(1);
                    state_next = ste_pkg::ST_SCAN_RD;
                end
            end

            ste_pkg::ST_SWAP_A: begin
                we         = 1'b1;
                waddr      = AW'(sel_reg);
                wdata      = rdata;
                state_next = ste_pkg::ST_SWAP_B;
            end

            ste_pkg::ST_SWAP_B: begin
                we    = 1'b1;
                waddr = AW'(pivot_reg);
                wdata = sv_reg;
                if (zph_reg) begin
                    pcol_next[qc] = 1'b1;
                    r_next        = pivot_reg + CW'(1);
                end else begin
                    r_next = '0;
                end
                state_next = ste_pkg::ST_ELIM_RD;
            end

            ste_pkg::ST_ELIM_RD: begin
                raddr = AW'(r_reg);
                if (r_reg >= n) begin
                    pivot_next = pivot_reg + CW'(1);
                    q_next     = q_reg + CW'(1);
                    sel_next   = pivot_reg + CW'(1);
                    state_next = ste_pkg::ST_SCAN_RD;
                end else if (!zph_reg && r_reg == pivot_reg) begin
                    r_next = r_reg + CW'(1);
                end else begin
                    state_next = ste_pkg::ST_ELIM_CHK;
                end
            end

            ste_pkg::ST_ELIM_CHK: begin
                if (hit) begin
                    we    = 1'b1;
                    waddr = AW'(r_reg);
                    wdata = prod.row;
                    if (prod.odd) begin
                        err_next = 1'b1;
                    end
                end
                r_next     = r_reg + CW'(1);
                state_next = ste_pkg::ST_ELIM_RD;
            end

            ste_pkg::ST_BS_RD: begin
                raddr = AW'(row_reg);
                if (pcol_reg[qc]) begin
                    state_next = ste_pkg::ST_BS_CHK;
                end else if (q_reg == '0) begin
                    state_next = ste_pkg::ST_EMIT;
                end else begin
                    q_next = q_reg - CW'(1);
                end
            end

            ste_pkg::ST_BS_CHK: begin
                base_next[qc] = rdata.sign ^ (^(rdata.z & m & base_reg));
                row_next      = row_reg - CW'(1);
                if (q_reg == '0) begin
                    state_next = ste_pkg::ST_EMIT;
                end else begin
                    q_next     = q_reg - CW'(1);
                    state_next = ste_pkg::ST_BS_RD;
                end
            end

            ste_pkg::ST_EMIT: begin
                row_next      = '0;
                out_rank_next = 7'(rank_reg);
                if (rank_reg == '0) begin
                    out_idx_next  = '0;
                    out_bits_next = '0;
                    out_last_next = 1'b1;
                    state_next    = ste_pkg::ST_OUT;
                end else begin
                    state_next = ste_pkg::ST_EM_RD;
                end
            end

            ste_pkg::ST_EM_RD: begin
                raddr      = AW'(row_reg);
                state_next = ste_pkg::ST_EM_LOAD;
            end

            ste_pkg::ST_EM_LOAD: begin
                out_idx_next  = 6'(row_reg);
                out_bits_next = rdata.x & m;
                out_last_next = (row_reg + CW'(1) == rank_reg);
                state_next    = ste_pkg::ST_OUT;
            end

            ste_pkg::ST_OUT: begin
                if (m_tready) begin
                    if (out_last_reg) begin
                        state_next = ste_pkg::ST_IDLE;
                    end else begin
                        row_next   = row_reg + CW'(1);
                        state_next = ste_pkg::ST_EM_RD;
                    end
                end
            end

            default: state_next = ste_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: dv/tableau_checker.sv
`default_nettype none
module tableau_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [15:0]  s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [143:0] m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         m_tuser,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [6:0]   cfg_data,
    output int                errors,
    output int                pending,
    output int                checked
);

    typedef struct packed {
        logic [6:0]  x_rank;
        logic [63:0] base_outcome;
        logic [5:0]  gen_index;
        logic [63:0] gen_bits;
        logic        is_last;
        logic        status;
    } outcome_t;

    logic [63:0] xp [64];
    logic [63:0] zp [64];
    logic        sg [64];
    logic [6:0]  qubit_reg;
    logic        phase_err;
    outcome_t    outcome_q [$];

    function automatic int eff_n();
        if (qubit_reg == 7'd0) return 1;
        if (qubit_reg > 7'd64) return 64;
        return int'(qubit_reg);
    endfunction

    task automatic start_state();
        for (int r = 0; r < 64; r++) begin
            xp[r] = '0;
            zp[r] = 64'd1 << r;
            sg[r] = 1'b0;
        end
    endtask

    task automatic apply_h(int n, int q);
        logic xb;
        logic zb;
        for (int r = 0; r < n; r++) begin
            xb = xp[r][q];
            zb = zp[r][q];
            sg[r] ^= xb & zb;
            xp[r][q] = zb;
            zp[r][q] = xb;
        end
    endtask

    task automatic apply_cnot(int n, int c, int t);
        logic xc;
        logic xt;
        logic zc;
        logic zt;
        for (int r = 0; r < n; r++) begin
            xc = xp[r][c];
            xt = xp[r][t];
            zc = zp[r][c];
            zt = zp[r][t];
            sg[r] ^= xc & zt & (xt == zc);
            if (xc) xp[r][t] ^= 1'b1;
            if (zt) zp[r][c] ^= 1'b1;
        end
    endtask

    task automatic exchange_rows(int a, int b);
        logic [63:0] tmp;
        logic s;
        tmp = xp[a]; xp[a] = xp[b]; xp[b] = tmp;
        tmp = zp[a]; zp[a] = zp[b]; zp[b] = tmp;
        s = sg[a]; sg[a] = sg[b]; sg[b] = s;
    endtask

    // row t becomes row s times row t
    task automatic row_times(int t, int s, logic [63:0] m);
        logic [63:0] tx;
        logic [63:0] tz;
        logic [63:0] sx;
        logic [63:0] sz;
        int e;
        tx = xp[t] & m;
        tz = zp[t] & m;
        sx = xp[s] & m;
        sz = zp[s] & m;
        e = 2 * sg[t] + 2 * sg[s] + $countones(tx & tz) + $countones(sx & sz)
            + 2 * $countones(tz & sx) + 4 - ($countones((tx ^ sx) & (tz ^ sz)) & 3);
        e = e & 3;
        if (e[0]) phase_err = 1'b1;
        sg[t] = e[1];
        xp[t] = (xp[t] ^ sx) & m;
        zp[t] = (zp[t] ^ sz) & m;
    endtask

    task automatic reduce_and_measure(int n);
        logic [63:0] m;
        logic [63:0] base;
        int pivot;
        int rank;
        int cnt;
        int sel;
        int row;
        int pcols [64];
        outcome_t o;
        m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        phase_err = 1'b0;
        pivot = 0;
        for (int q = 0; q < n && pivot < n; q++) begin
            sel = pivot;
            while (sel < n && !xp[sel][q]) sel++;
            if (sel == n) continue;
            exchange_rows(pivot, sel);
            for (int r = 0; r < n; r++)
                if (r != pivot && xp[r][q]) row_times(r, pivot, m);
            pivot++;
        end
        rank = pivot;
        cnt = 0;
        for (int q = 0; q < n && pivot < n; q++) begin
            sel = pivot;
            while (sel < n && !zp[sel][q]) sel++;
            if (sel == n) continue;
            exchange_rows(pivot, sel);
            for (int r = pivot + 1; r < n; r++)
                if (zp[r][q]) row_times(r, pivot, m);
            pcols[cnt] = q;
            cnt++;
            pivot++;
        end
        if (pivot != n) phase_err = 1'b1;
        base = '0;
        for (int k = cnt; k > 0; k--) begin
            row = rank + k - 1;
            base[pcols[k-1]] = sg[row] ^ ($countones(zp[row] & m & base) & 1);
        end
        if (rank == 0) begin
            o = '{x_rank: '0, base_outcome: base, gen_index: '0, gen_bits: '0,
                  is_last: 1'b1, status: phase_err};
            outcome_q = {outcome_q, o};
        end else begin
            for (int k = 0; k < rank; k++) begin
                o = '{x_rank: 7'(rank), base_outcome: base, gen_index: 6'(k),
                      gen_bits: xp[k] & m, is_last: (k + 1 == rank), status: phase_err};
                outcome_q = {outcome_q, o};
            end
        end
    endtask

    task automatic predict_word(logic [3:0] cmd, int a, int b);
        int n;
        n = eff_n();
        case (cmd) inside
            ste_pkg::CMD_INIT: start_state();
            ste_pkg::CMD_FINISH: reduce_and_measure(n);
            ste_pkg::CMD_H: if (a < n) apply_h(n, a);
            ste_pkg::CMD_X, ste_pkg::CMD_Y, ste_pkg::CMD_Z: begin
                if (a < n)
                    for (int r = 0; r < n; r++)
                        sg[r] ^= (cmd == ste_pkg::CMD_X) ? zp[r][a] :
                                 (cmd == ste_pkg::CMD_Y) ? (xp[r][a] ^ zp[r][a]) :
                                 xp[r][a];
            end
            ste_pkg::CMD_SWAP: begin
                if (a < n && b < n && a != b)
                    for (int r = 0; r < n; r++) begin
                        {xp[r][a], xp[r][b]} = {xp[r][b], xp[r][a]};
                        {zp[r][a], zp[r][b]} = {zp[r][b], zp[r][a]};
                    end
            end
            ste_pkg::CMD_CX: if (a < n && b < n && a != b) apply_cnot(n, a, b);
            ste_pkg::CMD_CZ: begin
                if (a < n && b < n && a != b) begin
                    apply_h(n, b);
                    apply_cnot(n, a, b);
                    apply_h(n, b);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            qubit_reg = 7'd64;
            start_state();
            outcome_q.delete();
            errors = 0;
            checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) qubit_reg = cfg_data;
            if (s_tvalid && s_tready)
                predict_word(s_tdata[3:0], int'(s_tdata[9:4]), int'(s_tdata[15:10]));
            if (m_tvalid && m_tready) begin
                got = '{x_rank: m_tdata[6:0], base_outcome: m_tdata[70:7],
                        gen_index: m_tdata[76:71], gen_bits: m_tdata[140:77],
                        is_last: m_tlast, status: m_tuser};
                checked++;
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result word %p", $time, got);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.x_rank !== want.x_rank ||
                        got.base_outcome !== want.base_outcome ||
                        got.gen_index !== want.gen_index ||
                        got.gen_bits !== want.gen_bits ||
                        got.is_last !== want.is_last ||
                        got.status !== want.status) begin
                        $display("%0t: mismatch expected %p", $time, want);
                        $display("%0t:          actual   %p", $time, got);
                        errors++;
                    end
                end
            end
        end
        pending = outcome_q.size();
    end

endmodule
`default_nettype wire

// File: dv/stabilizer_tableau_engine_tb.sv
`default_nettype none
module stabilizer_tableau_engine_tb;

    localparam int CYCLE_LIMIT = 10000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [6:0]   cfg_data = '0;
    int           errors;
    int           pending;
    int           checked;
    int           cycles = 0;
    int           words_sent = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    always #5 aclk = ~aclk;

    stabilizer_tableau_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    tableau_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);

    // valid stays high after acceptance until the next word or drain takes over
    task automatic send_word(logic [3:0] cmd, logic [5:0] a, logic [5:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, a, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_qubits(logic [6:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_word(int n);
        int k;
        logic [3:0] cmd;
        logic [5:0] a;
        logic [5:0] b;
        k = $urandom_range(99);
        a = ($urandom_range(99) < 85) ? 6'($urandom_range(n - 1)) : 6'($urandom);
        b = ($urandom_range(99) < 85) ? 6'($urandom_range(n - 1)) : 6'($urandom);
        if (k < 12) cmd = ste_pkg::CMD_FINISH;
        else if (k < 15) cmd = ste_pkg::CMD_INIT;
        else if (k < 18) cmd = 4'($urandom_range(15, 9));
        else cmd = 4'($urandom_range(ste_pkg::CMD_SWAP, ste_pkg::CMD_H));
        send_word(cmd, a, b);
    endtask

    logic [6:0] qubit_settings [6] = '{7'd3, 7'd127, 7'd0, 7'd5, 7'd64, 7'd2};
    int         n_eff;

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pass at full width
        send_word(ste_pkg::CMD_FINISH, 6'd0, 6'd0);
        send_word(ste_pkg::CMD_H, 6'd0, 6'd0);
        send_word(ste_pkg::CMD_H, 6'd63, 6'd0);
        send_word(ste_pkg::CMD_X, 6'd0, 6'd0);
        send_word(ste_pkg::CMD_Y, 6'd63, 6'd0);
        send_word(ste_pkg::CMD_Z, 6'd0, 6'd0);
        send_word(ste_pkg::CMD_CX, 6'd0, 6'd63);
        send_word(ste_pkg::CMD_CZ, 6'd63, 6'd0);
        send_word(ste_pkg::CMD_SWAP, 6'd0, 6'd63);
        send_word(ste_pkg::CMD_SWAP, 6'd5, 6'd5);
        send_word(ste_pkg::CMD_CX, 6'd7, 6'd7);
        send_word(ste_pkg::CMD_CZ, 6'd9, 6'd9);
        send_word(4'd9, 6'd1, 6'd2);
        send_word(4'd15, 6'd63, 6'd63);
        send_word(ste_pkg::CMD_FINISH, 6'd0, 6'd0);
        send_word(ste_pkg::CMD_INIT, 6'd0, 6'd0);
        send_word(ste_pkg::CMD_X, 6'd3, 6'd0);
        send_word(ste_pkg::CMD_FINISH, 6'd0, 6'd0);
        send_word(ste_pkg::CMD_H, 6'd1, 6'd0);
        send_word(ste_pkg::CMD_CX, 6'd1, 6'd2);
        send_word(ste_pkg::CMD_Z, 6'd2, 6'd0);
        send_word(ste_pkg::CMD_FINISH, 6'd0, 6'd0);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_qubits(qubit_settings[p]);
            n_eff = (qubit_settings[p] == 0) ? 1 :
                    (qubit_settings[p] > 64) ? 64 : int'(qubit_settings[p]);
            case (p % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 73; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 73; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int i = 0; i < 16; i++) random_word(n_eff);
            send_word(ste_pkg::CMD_FINISH, 6'd0, 6'd0);
            drain();
        end

        $display("sent %0d words over qubit counts 1 to 64, checked %0d result words",
                 words_sent, checked);
        $display("phases ran with no idling, sender gaps, receiver stalls and both");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
